// ----- rtl/ctl_pkg.sv -----
// Shared types and constants for the configuration text tokenizer.
`default_nettype none

package ctl_pkg;

  // Up to three tokens can come out of one text byte.
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned FifoDepth = 4;

  // Configuration register indexes
  localparam logic CFG_SKIP_COMMENTS = 1'b0;
  localparam logic CFG_SKIP_SPACES   = 1'b1;

  // Character codes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_SQSTR = 3'd2,
    MODE_DQSTR = 3'd3,
    MODE_CMT   = 3'd4,
    MODE_WS    = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    TOK_UNTERM    = 4'd0,
    TOK_COMMENT   = 4'd1,
    TOK_SPACE     = 4'd2,
    TOK_LPAREN    = 4'd3,
    TOK_RPAREN    = 4'd4,
    TOK_OPEN      = 4'd5,
    TOK_CLOSE     = 4'd6,
    TOK_SEMICOLON = 4'd7,
    TOK_IDENT     = 4'd8,
    TOK_STRING    = 4'd9,
    TOK_EOF       = 4'd10
  } tok_type_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    tok_type_e   token_type;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/ctl_lex_core.sv -----
// Lexer state registers and the per-byte token decision.
`default_nettype none

module ctl_lex_core #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire ctl_pkg::in_item_t                item_i,
  input  wire logic                             skip_comments_i,
  input  wire logic                             skip_spaces_i,
  output ctl_pkg::out_item_t [ctl_pkg::MaxRes-1:0] tok_o,
  output logic [1:0]                            tok_cnt_o
);

  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};

  ctl_pkg::mode_e          mode_q, mode_d;
  logic                    esc_q, esc_d;
  logic                    inv_q, inv_d;
  logic [7:0]              prev_q, prev_d;
  logic [OFFSET_BITS-1:0]  pos_q, pos_d;
  logic [OFFSET_BITS-1:0]  ts_q, ts_d;

  // Candidate tokens: slot 0 closes the open token, slot 1 is a start-mode
  // token or the flush, slot 2 is end of input.
  logic                    cand_v [3];
  ctl_pkg::tok_type_e      cand_t [3];
  logic [OFFSET_BITS-1:0]  cand_s [3];
  logic [OFFSET_BITS-1:0]  cand_e [3];

  function automatic logic is_ws(input logic [7:0] b);
    return b == ctl_pkg::CH_SPACE || b == ctl_pkg::CH_NL || b == ctl_pkg::CH_TAB;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] x);
    return (x == OffMax) ? x : x + OFFSET_BITS'(1);
  endfunction

  function automatic logic [31:0] off32(input logic [OFFSET_BITS-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  // Next state and candidate tokens
  always_comb begin
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] nxt;
    logic                   do_start;
    b        = item_i.text_byte;
    nxt      = sat_inc(pos_q);
    do_start = 1'b0;
    mode_d   = mode_q;
    esc_d    = esc_q;
    inv_d    = inv_q;
    ts_d     = ts_q;
    for (int i = 0; i < 3; i++) begin
      cand_v[i] = 1'b0;
      cand_t[i] = ctl_pkg::TOK_UNTERM;
      cand_s[i] = '0;
      cand_e[i] = '0;
    end

    unique case (mode_q)
      ctl_pkg::MODE_IDENT: begin
        if (is_ws(b) || b == ctl_pkg::CH_SEMI || b == ctl_pkg::CH_LBRACE ||
            b == ctl_pkg::CH_RBRACE) begin
          if (b == ctl_pkg::CH_LBRACE && prev_q == ctl_pkg::CH_DOLLAR) begin
            inv_d = 1'b1;
          end else if (b == ctl_pkg::CH_RBRACE && inv_q) begin
            inv_d = 1'b0;
          end else begin
            cand_v[0] = 1'b1;
            cand_t[0] = ctl_pkg::TOK_IDENT;
            cand_s[0] = ts_q;
            cand_e[0] = pos_q;
            mode_d    = ctl_pkg::MODE_START;
            do_start  = 1'b1;
          end
        end
      end
      ctl_pkg::MODE_SQSTR, ctl_pkg::MODE_DQSTR: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (b == ctl_pkg::CH_BSLASH) begin
          esc_d = 1'b1;
        end else if (b == ((mode_q == ctl_pkg::MODE_SQSTR) ? ctl_pkg::CH_SQUOTE
                                                          : ctl_pkg::CH_DQUOTE)) begin
          cand_v[0] = 1'b1;
          cand_t[0] = ctl_pkg::TOK_STRING;
          cand_s[0] = ts_q;
          cand_e[0] = nxt;
          mode_d    = ctl_pkg::MODE_START;
        end
      end
      ctl_pkg::MODE_CMT: begin
        if (b == ctl_pkg::CH_NL) begin
          cand_v[0] = 1'b1;
          cand_t[0] = ctl_pkg::TOK_COMMENT;
          cand_s[0] = ts_q;
          cand_e[0] = nxt;
          mode_d    = ctl_pkg::MODE_START;
        end
      end
      ctl_pkg::MODE_WS: begin
        if (!is_ws(b)) begin
          cand_v[0] = 1'b1;
          cand_t[0] = ctl_pkg::TOK_SPACE;
          cand_s[0] = ts_q;
          cand_e[0] = pos_q;
          mode_d    = ctl_pkg::MODE_START;
          do_start  = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // Start-mode look at the byte; runs at most once per byte
    if (do_start) begin
      ts_d      = pos_q;
      cand_s[1] = pos_q;
      cand_e[1] = nxt;
      case (b)
        ctl_pkg::CH_HASH:   mode_d = ctl_pkg::MODE_CMT;
        ctl_pkg::CH_SPACE, ctl_pkg::CH_NL, ctl_pkg::CH_TAB: mode_d = ctl_pkg::MODE_WS;
        ctl_pkg::CH_LPAREN: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_LPAREN;
        end
        ctl_pkg::CH_RPAREN: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_RPAREN;
        end
        ctl_pkg::CH_LBRACE: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_OPEN;
        end
        ctl_pkg::CH_RBRACE: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_CLOSE;
        end
        ctl_pkg::CH_SEMI: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_SEMICOLON;
        end
        ctl_pkg::CH_SQUOTE: begin
          mode_d = ctl_pkg::MODE_SQSTR;
          esc_d  = 1'b0;
        end
        ctl_pkg::CH_DQUOTE: begin
          mode_d = ctl_pkg::MODE_DQSTR;
          esc_d  = 1'b0;
        end
        default: begin
          mode_d = ctl_pkg::MODE_IDENT;
          inv_d  = 1'b0;
        end
      endcase
    end

    prev_d = b;
    pos_d  = nxt;

    if (item_i.last_byte) begin
      // Flush never collides with a start-mode token: that leaves mode START
      case (mode_d)
        ctl_pkg::MODE_CMT: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_COMMENT;
        end
        ctl_pkg::MODE_WS: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_SPACE;
        end
        ctl_pkg::MODE_IDENT, ctl_pkg::MODE_SQSTR, ctl_pkg::MODE_DQSTR: begin
          cand_v[1] = 1'b1;
          cand_t[1] = ctl_pkg::TOK_UNTERM;
        end
        default: ;
      endcase
      if (mode_d != ctl_pkg::MODE_START) begin
        cand_s[1] = ts_d;
        cand_e[1] = nxt;
      end
      cand_v[2] = 1'b1;
      cand_t[2] = ctl_pkg::TOK_EOF;
      mode_d    = ctl_pkg::MODE_START;
      esc_d     = 1'b0;
      inv_d     = 1'b0;
      prev_d    = '0;
      pos_d     = '0;
      ts_d      = '0;
    end
  end

  // Skip filtering and packing into consecutive result slots
  always_comb begin
    logic [1:0] cnt;
    logic       keep;
    cnt   = 2'd0;
    tok_o = '0;
    for (int i = 0; i < 3; i++) begin
      keep = cand_v[i] &&
             !(cand_t[i] == ctl_pkg::TOK_COMMENT && skip_comments_i) &&
             !(cand_t[i] == ctl_pkg::TOK_SPACE && skip_spaces_i);
      if (keep) begin
        tok_o[cnt].token_type   = cand_t[i];
        tok_o[cnt].start_offset = off32(cand_s[i]);
        tok_o[cnt].end_offset   = off32(cand_e[i]);
        tok_o[cnt].last_of_run  = 1'b0;
        cnt = cnt + 2'd1;
      end
    end
    if (cnt != 2'd0) begin
      tok_o[cnt - 2'd1].last_of_run = 1'b1;
    end
    tok_cnt_o = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ctl_pkg::MODE_START;
      esc_q  <= 1'b0;
      inv_q  <= 1'b0;
      prev_q <= '0;
      pos_q  <= '0;
      ts_q   <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      inv_q  <= inv_d;
      prev_q <= prev_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/config_token_lexer.sv -----
// Output: a token is registered into the result queue when its text byte transfers.
// Throughput: one byte per cycle while each byte yields at most one token and
// the output is not stalled; a byte yielding two or three tokens drains them one
// per cycle while the output is not stalled, from a four-entry result queue, and
// input stalls while the queue holds two or more. Reset: lexer state, offset counter, queue and both skip flags clear.
// Top level of the configuration text tokenizer.
`default_nettype none

module config_token_lexer #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ctl_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ctl_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic               cfg_data_i
);

  localparam int unsigned PtrW = $clog2(ctl_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(ctl_pkg::FifoDepth + 1);

  logic skip_comments_q, skip_spaces_q;
  logic in_acc, out_acc;

  ctl_pkg::out_item_t [ctl_pkg::MaxRes-1:0] tok;
  logic [1:0]                               tok_cnt;

  ctl_pkg::out_item_t fifo_q [ctl_pkg::FifoDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;

  assign in_stall_o  = count_q > CntW'(ctl_pkg::FifoDepth - ctl_pkg::MaxRes);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[rd_ptr_q];

  ctl_lex_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_acc),
    .item_i         (in_data_i),
    .skip_comments_i(skip_comments_q),
    .skip_spaces_i  (skip_spaces_q),
    .tok_o          (tok),
    .tok_cnt_o      (tok_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_comments_q <= 1'b0;
      skip_spaces_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ctl_pkg::CFG_SKIP_COMMENTS: skip_comments_q <= cfg_data_i;
        ctl_pkg::CFG_SKIP_SPACES:   skip_spaces_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Result queue: up to three pushes and one pop per cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < ctl_pkg::MaxRes; k++) begin
        if (2'(k) < tok_cnt) begin
          fifo_q[wr_ptr_q + PtrW'(k)] <= tok[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(tok_cnt);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (in_acc ? CntW'(tok_cnt) : CntW'(0))
                         - (out_acc ? CntW'(1) : CntW'(0));
    end
  end

  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (count_q + CntW'(tok_cnt)) <= CntW'(ctl_pkg::FifoDepth))
    else $error("result queue overflow");

  a_last_yields_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_byte) |-> tok_cnt != 2'd0)
    else $error("last byte produced no token");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ctl_pkg::FifoDepth))
    else $error("queue count out of range");

  a_pop_moves_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> rd_ptr_q == $past(rd_ptr_q) + PtrW'(1))
    else $error("read pointer did not advance on transfer");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the config text tokenizer: directed and random text vs a token predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int TimeoutCycles = 200000;

  // Predicts the tokens of each byte and checks the tokens that come out.
  class token_scoreboard;
    bit                  skip_cmt;
    bit                  skip_ws;
    ctl_pkg::mode_e      mode;
    bit                  esc;
    bit                  in_var;
    logic [7:0]          prev_byte;
    logic [31:0]         pos;
    logic [31:0]         tok_start;
    ctl_pkg::out_item_t  pending_q[$];
    ctl_pkg::out_item_t  byte_toks[$];
    int                  errors;

    function new();
      errors   = 0;
      skip_cmt = 1'b0;
      skip_ws  = 1'b0;
      clear_text();
    endfunction

    function void clear_text();
      mode      = ctl_pkg::MODE_START;
      esc       = 1'b0;
      in_var    = 1'b0;
      prev_byte = '0;
      pos       = '0;
      tok_start = '0;
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == ctl_pkg::CFG_SKIP_COMMENTS) skip_cmt = val;
      else skip_ws = val;
    endfunction

    function logic [31:0] bump(logic [31:0] x);
      return (x == '1) ? x : x + 32'd1;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == ctl_pkg::CH_SPACE || b == ctl_pkg::CH_NL || b == ctl_pkg::CH_TAB;
    endfunction

    function void add_token(ctl_pkg::tok_type_e t, logic [31:0] s, logic [31:0] e);
      ctl_pkg::out_item_t tok;
      if (t == ctl_pkg::TOK_COMMENT && skip_cmt) return;
      if (t == ctl_pkg::TOK_SPACE && skip_ws) return;
      if (byte_toks.size() >= ctl_pkg::MaxRes) return;
      tok.token_type   = t;
      tok.start_offset = s;
      tok.end_offset   = e;
      tok.last_of_run  = 1'b0;
      byte_toks.push_back(tok);
    endfunction

    // Returns 1 when the byte closed a token and is scanned again from start mode.
    function bit scan(logic [7:0] b, logic [31:0] p);
      case (mode)
        ctl_pkg::MODE_IDENT: begin
          if (is_blank(b) || b == ctl_pkg::CH_SEMI || b == ctl_pkg::CH_LBRACE ||
              b == ctl_pkg::CH_RBRACE) begin
            if (b == ctl_pkg::CH_LBRACE && prev_byte == ctl_pkg::CH_DOLLAR) begin
              in_var = 1'b1;
              return 1'b0;
            end
            if (b == ctl_pkg::CH_RBRACE && in_var) begin
              in_var = 1'b0;
              return 1'b0;
            end
            add_token(ctl_pkg::TOK_IDENT, tok_start, p);
            mode = ctl_pkg::MODE_START;
            return 1'b1;
          end
        end
        ctl_pkg::MODE_SQSTR, ctl_pkg::MODE_DQSTR: begin
          if (esc) begin
            esc = 1'b0;
          end else if (b == ctl_pkg::CH_BSLASH) begin
            esc = 1'b1;
          end else if (b == ((mode == ctl_pkg::MODE_SQSTR) ? ctl_pkg::CH_SQUOTE
                                                           : ctl_pkg::CH_DQUOTE)) begin
            add_token(ctl_pkg::TOK_STRING, tok_start, bump(p));
            mode = ctl_pkg::MODE_START;
          end
        end
        ctl_pkg::MODE_CMT: begin
          if (b == ctl_pkg::CH_NL) begin
            add_token(ctl_pkg::TOK_COMMENT, tok_start, bump(p));
            mode = ctl_pkg::MODE_START;
          end
        end
        ctl_pkg::MODE_WS: begin
          if (!is_blank(b)) begin
            add_token(ctl_pkg::TOK_SPACE, tok_start, p);
            mode = ctl_pkg::MODE_START;
            return 1'b1;
          end
        end
        default: begin
          tok_start = p;
          case (b)
            ctl_pkg::CH_HASH:   mode = ctl_pkg::MODE_CMT;
            ctl_pkg::CH_SPACE, ctl_pkg::CH_NL, ctl_pkg::CH_TAB: mode = ctl_pkg::MODE_WS;
            ctl_pkg::CH_LPAREN: add_token(ctl_pkg::TOK_LPAREN, p, bump(p));
            ctl_pkg::CH_RPAREN: add_token(ctl_pkg::TOK_RPAREN, p, bump(p));
            ctl_pkg::CH_LBRACE: add_token(ctl_pkg::TOK_OPEN, p, bump(p));
            ctl_pkg::CH_RBRACE: add_token(ctl_pkg::TOK_CLOSE, p, bump(p));
            ctl_pkg::CH_SEMI:   add_token(ctl_pkg::TOK_SEMICOLON, p, bump(p));
            ctl_pkg::CH_SQUOTE: begin
              mode = ctl_pkg::MODE_SQSTR;
              esc  = 1'b0;
            end
            ctl_pkg::CH_DQUOTE: begin
              mode = ctl_pkg::MODE_DQSTR;
              esc  = 1'b0;
            end
            default: begin
              mode   = ctl_pkg::MODE_IDENT;
              in_var = 1'b0;
            end
          endcase
        end
      endcase
      return 1'b0;
    endfunction

    function void note_byte(ctl_pkg::in_item_t it);
      logic [31:0]        nxt;
      ctl_pkg::out_item_t tail;
      byte_toks.delete();
      if (scan(it.text_byte, pos)) void'(scan(it.text_byte, pos));
      prev_byte = it.text_byte;
      nxt       = bump(pos);
      pos       = nxt;
      if (it.last_byte) begin
        // flush whatever token is still open, then end of input
        case (mode)
          ctl_pkg::MODE_CMT: add_token(ctl_pkg::TOK_COMMENT, tok_start, nxt);
          ctl_pkg::MODE_WS:  add_token(ctl_pkg::TOK_SPACE, tok_start, nxt);
          ctl_pkg::MODE_IDENT, ctl_pkg::MODE_SQSTR, ctl_pkg::MODE_DQSTR:
            add_token(ctl_pkg::TOK_UNTERM, tok_start, nxt);
          default: ;
        endcase
        add_token(ctl_pkg::TOK_EOF, '0, '0);
        clear_text();
      end
      if (byte_toks.size() > 0) begin
        tail = byte_toks.pop_back();
        tail.last_of_run = 1'b1;
        byte_toks.push_back(tail);
      end
      foreach (byte_toks[i]) pending_q.push_back(byte_toks[i]);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_token(ctl_pkg::out_item_t got);
      ctl_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: type %0d start %0d end %0d", $time,
                 got.token_type, got.start_offset, got.end_offset);
        return;
      end
      want = pending_q.pop_front();
      check_field("token_type", 32'(want.token_type), 32'(got.token_type));
      check_field("start_offset", want.start_offset, got.start_offset);
      check_field("end_offset", want.end_offset, got.end_offset);
      check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  ctl_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  ctl_pkg::out_item_t out_data_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic               cfg_data_i;

  token_scoreboard    tokens;
  logic [7:0]         text_q[$];
  bit                 no_gaps;
  int                 bytes_sent;
  int                 cycles = 0;
  ctl_pkg::out_item_t seen_tok;

  config_token_lexer dut (.clk_i(clk), .*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TimeoutCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side stalls: mostly short bursts, now and then a long quiet stretch.
  initial begin
    int r;
    int n;
    out_stall_i = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 4);
      else if (r < 90) n = $urandom_range(5, 15);
      else n = $urandom_range(30, 80);
      repeat (n) @(posedge clk);
      out_stall_i <= 1'b1;
      n = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      repeat (n) @(posedge clk);
      out_stall_i <= 1'b0;
    end
  end

  // Values are stable at the falling edge; a transfer happens at the next rising edge.
  always @(negedge clk) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen_tok = out_data_o;
      @(posedge clk);
      tokens.check_token(seen_tok);
    end
  end

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else n = $urandom_range(6, 20);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_text();
    ctl_pkg::in_item_t it;
    bit                taken;
    foreach (text_q[i]) begin
      idle_gap();
      it.text_byte = text_q[i];
      it.last_byte = (i == text_q.size() - 1);
      in_valid_i <= 1'b1;
      in_data_i  <= it;
      do begin
        @(negedge clk);
        taken = !in_stall_o;
        @(posedge clk);
      end while (!taken);
      tokens.note_byte(it);
      bytes_sent++;
    end
    text_q.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic write_flags(logic skip_c, logic skip_s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ctl_pkg::CFG_SKIP_COMMENTS;
    cfg_data_i <= skip_c;
    @(posedge clk);
    tokens.set_reg(ctl_pkg::CFG_SKIP_COMMENTS, skip_c);
    cfg_idx_i  <= ctl_pkg::CFG_SKIP_SPACES;
    cfg_data_i <= skip_s;
    @(posedge clk);
    tokens.set_reg(ctl_pkg::CFG_SKIP_SPACES, skip_s);
    cfg_we_i <= 1'b0;
  endtask

  // Stops input and waits until every predicted token has come out, then idles before returning.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (tokens.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Builds one text of mostly well-formed pieces with random content and some noise.
  task automatic build_text();
    string      idc;
    int         pieces;
    int         r;
    int         n;
    logic [7:0] q;
    logic [7:0] c;
    logic [7:0] punct[5];
    logic [7:0] blank[3];
    idc    = "abcxyzAZ09_.-/:$";
    punct  = '{ctl_pkg::CH_LPAREN, ctl_pkg::CH_RPAREN, ctl_pkg::CH_LBRACE,
               ctl_pkg::CH_RBRACE, ctl_pkg::CH_SEMI};
    blank  = '{ctl_pkg::CH_SPACE, ctl_pkg::CH_TAB, ctl_pkg::CH_NL};
    pieces = $urandom_range(2, 10);
    for (int k = 0; k < pieces; k++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) text_q.push_back(idc[$urandom_range(0, idc.len() - 1)]);
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(ctl_pkg::CH_DOLLAR);
          text_q.push_back(ctl_pkg::CH_LBRACE);
          n = $urandom_range(0, 4);
          for (int j = 0; j < n; j++) text_q.push_back(idc[$urandom_range(0, 8)]);
          if ($urandom_range(0, 4) != 0) text_q.push_back(ctl_pkg::CH_RBRACE);
        end
      end else if (r < 40) begin
        n = $urandom_range(1, 3);
        for (int j = 0; j < n; j++) text_q.push_back(blank[$urandom_range(0, 2)]);
      end else if (r < 52) begin
        q = $urandom_range(0, 1) ? ctl_pkg::CH_SQUOTE : ctl_pkg::CH_DQUOTE;
        text_q.push_back(q);
        n = $urandom_range(0, 6);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 4) == 0) begin
            text_q.push_back(ctl_pkg::CH_BSLASH);
            text_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            c = 8'($urandom_range(32, 126));
            if (c == q || c == ctl_pkg::CH_BSLASH) c = "a";
            text_q.push_back(c);
          end
        end
        if ($urandom_range(0, 6) != 0) text_q.push_back(q);
      end else if (r < 62) begin
        text_q.push_back(ctl_pkg::CH_HASH);
        n = $urandom_range(0, 8);
        for (int j = 0; j < n; j++) text_q.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 9) != 0) text_q.push_back(ctl_pkg::CH_NL);
      end else if (r < 82) begin
        text_q.push_back(punct[$urandom_range(0, 4)]);
      end else begin
        n = $urandom_range(1, 3);
        for (int j = 0; j < n; j++) text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    tokens     = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = ctl_pkg::CFG_SKIP_COMMENTS;
    cfg_data_i = 1'b0;
    no_gaps    = 1'b0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    write_flags(1'b0, 1'b0);

    // comment, parens, braces, identifier with a variable, blank run ended by ';'
    add_str("#c\n(){a${v}}\t;");
    send_text();
    // escaped quote inside a string, then a string cut off by the last byte
    add_str("'\\''\"x");
    send_text();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    // blank run and comment flushed at the last byte
    add_str(" ");
    send_text();
    add_str("#");
    send_text();

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain();
        write_flags(ph == 1 || ph == 2, ph == 1 || ph == 3);
      end
      bytes_sent = 0;
      while (bytes_sent < 40) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        build_text();
        send_text();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (tokens.errors == 0 && tokens.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
